/* rtl/bfsp_pkg.sv */
// bfsp_pkg: shared types and fixed constants for the Bellman-Ford block.
// No dependencies; imported by every module in rtl/.
package bfsp_pkg;

    // fixed field widths
    localparam int VTX_BITS      = 5;
    localparam int COST_BITS     = 32;
    localparam int VC_BITS       = 6;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // register indexes (paddr[2])
    localparam logic REG_VERTEX_COUNT  = 1'b0;
    localparam logic REG_SOURCE_VERTEX = 1'b1;

    // register reset values
    localparam logic [VC_BITS-1:0]  VC_RESET  = 6'd32;
    localparam logic [VTX_BITS-1:0] SRC_RESET = 5'd1;

    // saturation limits
    localparam logic signed [COST_BITS-1:0] COST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COST_BITS-1:0] COST_MIN = 32'sh8000_0000;

    // sequencer -> relax unit commands
    typedef struct packed {
        logic clear_marks;  // drop all reached marks
        logic seed;         // dist[addr_u] = 0, mark it reached
        logic dist_rd;      // read dist at addr_u and addr_v
        logic cand_ld;      // register saturated dist[u] + weight
        logic commit;       // dist[addr_v] = candidate, mark it reached
    } bfsp_relax_ctl_t;

    // relax unit -> sequencer status
    typedef struct packed {
        logic mark_u;       // reached mark at addr_u
        logic better;       // candidate improves vertex addr_v
    } bfsp_relax_sts_t;

endpackage

/* rtl/bellman_ford_shortest_paths.sv */
// bellman_ford_shortest_paths: top level with config registers, run sequencer and results.
// Depends on bfsp_pkg, bfsp_edge_table and bfsp_relax.
//
// Usage: edges are requests on start / busy; one is taken at each clock edge where start
// is high and busy is low, so a graph loads at one edge per cycle. The edge with
// last_edge set is stored too while the table has room and starts the run; busy then
// stays high until the last result has been issued. The run has an init step and then
// vertex_count-1 passes over the E stored edges (vertex_count-2 relaxing passes and one
// check pass). Per pass the sequencer fetches each edge (FETCH, EDGE); an edge whose
// source is reached and in range then goes through the shared add / compare unit (ADD,
// CMP), and a pass-end step closes the pass. Results are strobed by done, one per cycle,
// vertices 1 to count-1, the first one after the pass-end step of the check pass has
// moved the sequencer to S_OUT, whose result outputs are registered; a negative cycle
// gives one result instead, in the cycle after the edge that still relaxes.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Registers are written over APB (vertex_count at 0x0, source_vertex at 0x4) by the user
// only while busy is low; the block does not enforce it. Reset empties the edge table,
// drops all marks and sets vertex_count 32 and source_vertex 1; no clearing pass is needed.
module bellman_ford_shortest_paths
    import bfsp_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_BITS-1:0]      paddr,
    input  logic [CFG_DATA_BITS-1:0]      pwdata,
    output logic [CFG_DATA_BITS-1:0]      prdata,
    output logic                          pready,
    // edge requests
    input  logic                          start,
    output logic                          busy,
    input  logic [VTX_BITS-1:0]           edge_from,
    input  logic [VTX_BITS-1:0]           edge_to,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic                          last_edge,
    // results
    output logic                          done,
    output logic [VTX_BITS-1:0]           vertex,
    output logic signed [COST_BITS-1:0]   path_cost,
    output logic                          reachable,
    output logic                          negative_cycle,
    output logic                          last
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int CMPW = NW + VC_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EDGE  = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          state_reg,  state_next;
    logic [VC_BITS-1:0]  vc_reg;
    logic [VTX_BITS-1:0] src_reg;
    logic [NW-1:0]       n_reg,      n_next;
    logic [NW-1:0]       pass_reg,   pass_next;
    logic                check_reg,  check_next;
    logic [CW-1:0]       idx_reg,    idx_next;
    logic [NW-1:0]       v_reg,      v_next;

    logic                out_valid_reg, out_valid_next;
    logic [VTX_BITS-1:0] out_vtx_reg,   out_vtx_next;
    logic                out_reach_reg, out_reach_next;
    logic                out_neg_reg,   out_neg_next;
    logic                out_last_reg,  out_last_next;

    logic                          accept;
    logic                          cfg_wr;
    logic                          edge_clear;
    logic                          edge_rd;
    logic [CW-1:0]                 edge_count;
    logic [VTX_BITS-1:0]           e_from;
    logic [VTX_BITS-1:0]           e_to;
    logic signed [WEIGHT_BITS-1:0] e_weight;
    logic                          src_ok;
    logic                          edge_ok;
    logic [VW-1:0]                 addr_u;
    logic [VW-1:0]                 addr_v;
    bfsp_relax_ctl_t               rctl;
    bfsp_relax_sts_t               rsts;
    logic signed [COST_BITS-1:0]   dist_a;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // APB registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg  <= VC_RESET;
            src_reg <= SRC_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_VERTEX_COUNT:  vc_reg  <= pwdata[VC_BITS-1:0];
                REG_SOURCE_VERTEX: src_reg <= pwdata[VTX_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_VERTEX_COUNT:  prdata = CFG_DATA_BITS'(vc_reg);
            REG_SOURCE_VERTEX: prdata = CFG_DATA_BITS'(src_reg);
            default:           prdata = '0;
        endcase
    end

    // vertex count clamped to 2..MAX_VERTICES at run start
    always_comb
    begin
        if (CMPW'(vc_reg) > CMPW'(MAX_VERTICES))
        begin
            n_next = NW'(MAX_VERTICES);
        end
        else if (vc_reg < VC_BITS'(2))
        begin
            n_next = NW'(2);
        end
        else
        begin
            n_next = NW'(vc_reg);
        end
    end

    // range checks against the clamped count
    assign src_ok  = (src_reg != '0) && (CMPW'(src_reg) < CMPW'(n_reg));
    assign edge_ok = (e_from != '0) && (CMPW'(e_from) < CMPW'(n_reg))
                  && (e_to != '0) && (CMPW'(e_to) < CMPW'(n_reg));

    // relax unit address select
    always_comb
    begin
        unique case (state_reg)
            S_INIT:  addr_u = VW'(src_reg);
            S_OUT:   addr_u = VW'(v_reg);
            default: addr_u = VW'(e_from);
        endcase
    end
    assign addr_v = VW'(e_to);

    // run sequencer
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        check_next     = check_reg;
        idx_next       = idx_reg;
        v_next         = v_reg;
        out_valid_next = 1'b0;
        out_vtx_next   = out_vtx_reg;
        out_reach_next = out_reach_reg;
        out_neg_next   = out_neg_reg;
        out_last_next  = out_last_reg;
        edge_clear     = 1'b0;
        edge_rd        = 1'b0;
        rctl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && last_edge)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                rctl.clear_marks = 1'b1;
                rctl.seed        = src_ok;
                pass_next        = '0;
                idx_next         = '0;
                check_next       = (n_reg == NW'(2));
                state_next       = S_FETCH;
            end
            S_FETCH:
            begin
                if (idx_reg == edge_count)
                begin
                    // end of pass
                    idx_next = '0;
                    if (check_reg)
                    begin
                        v_next     = NW'(1);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + NW'(1);
                        check_next = (CMPW'(pass_reg) + CMPW'(3)) >= CMPW'(n_reg);
                    end
                end
                else
                begin
                    edge_rd    = 1'b1;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (edge_ok && rsts.mark_u)
                begin
                    rctl.dist_rd = 1'b1;
                    state_next   = S_ADD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_FETCH;
                end
            end
            S_ADD:
            begin
                rctl.cand_ld = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_FETCH;
                if (rsts.better)
                begin
                    if (check_reg)
                    begin
                        // still relaxing after the last pass: negative cycle
                        out_valid_next = 1'b1;
                        out_vtx_next   = '0;
                        out_reach_next = 1'b0;
                        out_neg_next   = 1'b1;
                        out_last_next  = 1'b1;
                        edge_clear     = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        rctl.commit = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                rctl.dist_rd   = 1'b1;
                out_valid_next = 1'b1;
                out_vtx_next   = VTX_BITS'(v_reg);
                out_reach_next = rsts.mark_u;
                out_neg_next   = 1'b0;
                out_last_next  = (CMPW'(v_reg) + CMPW'(1)) == CMPW'(n_reg);
                v_next         = v_reg + NW'(1);
                if (out_last_next)
                begin
                    edge_clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= NW'(2);
            pass_reg      <= '0;
            check_reg     <= 1'b0;
            idx_reg       <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_reach_reg <= 1'b0;
            out_neg_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (accept && last_edge)
            begin
                n_reg <= n_next;
            end
            pass_reg      <= pass_next;
            check_reg     <= check_next;
            idx_reg       <= idx_next;
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
            out_reach_reg <= out_reach_next;
            out_neg_reg   <= out_neg_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_vtx_reg <= out_vtx_next;
    end

    bfsp_edge_table #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_edge_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_from   (edge_from),
        .wr_to     (edge_to),
        .wr_weight (edge_weight),
        .clear     (edge_clear),
        .rd_en     (edge_rd),
        .rd_idx    (idx_reg[AW-1:0]),
        .count     (edge_count),
        .rd_from   (e_from),
        .rd_to     (e_to),
        .rd_weight (e_weight)
    );

    bfsp_relax #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_relax (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rctl),
        .addr_u (addr_u),
        .addr_v (addr_v),
        .weight (e_weight),
        .sts    (rsts),
        .dist_a (dist_a)
    );

    // result ports
    assign done           = out_valid_reg;
    assign vertex         = out_vtx_reg;
    assign path_cost      = out_reach_reg ? dist_a : '0;
    assign reachable      = out_reach_reg;
    assign negative_cycle = out_neg_reg;
    assign last           = out_last_reg;

    // checks
    a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_edge |=> busy)
        else $error("run did not start after last edge");

    a_neg_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        done && negative_cycle |-> last && (vertex == '0) && !reachable)
        else $error("negative cycle result malformed");

    a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !reachable |-> (path_cost == '0))
        else $error("unreached vertex with nonzero cost");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |=> !done)
        else $error("result after final result of run");

endmodule

/* rtl/bfsp_edge_table.sv */
// bfsp_edge_table: edge memory with fill count, one write and one registered read port.
// Depends on bfsp_pkg.
module bfsp_edge_table
    import bfsp_pkg::*;
#(
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16,
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int CW = $clog2(MAX_EDGES + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [VTX_BITS-1:0]           wr_from,
    input  logic [VTX_BITS-1:0]           wr_to,
    input  logic signed [WEIGHT_BITS-1:0] wr_weight,
    input  logic                          clear,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_idx,
    output logic [CW-1:0]                 count,
    output logic [VTX_BITS-1:0]           rd_from,
    output logic [VTX_BITS-1:0]           rd_to,
    output logic signed [WEIGHT_BITS-1:0] rd_weight
);

    localparam int EW = 2 * VTX_BITS + WEIGHT_BITS;

    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [EW-1:0] rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic          store;

    assign full  = (count_reg == CW'(MAX_EDGES));
    assign store = wr_en && !full;

    // fill count; edges past a full table are dropped
    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (store)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // edge storage
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            edge_mem[count_reg[AW-1:0]] <= {wr_from, wr_to, wr_weight};
        end
        if (rd_en)
        begin
            rd_data_reg <= edge_mem[rd_idx];
        end
    end

    assign count     = count_reg;
    assign rd_from   = rd_data_reg[EW-1 -: VTX_BITS];
    assign rd_to     = rd_data_reg[WEIGHT_BITS +: VTX_BITS];
    assign rd_weight = rd_data_reg[WEIGHT_BITS-1:0];

endmodule

/* rtl/bfsp_relax.sv */
// bfsp_relax: distance memory, reached marks and the shared saturating add / compare unit.
// Depends on bfsp_pkg.
module bfsp_relax
    import bfsp_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16,
    localparam int VW = $clog2(MAX_VERTICES)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfsp_relax_ctl_t               ctl,
    input  logic [VW-1:0]                 addr_u,
    input  logic [VW-1:0]                 addr_v,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    output bfsp_relax_sts_t               sts,
    output logic signed [COST_BITS-1:0]   dist_a
);

    logic signed [COST_BITS-1:0] dist_mem [MAX_VERTICES];
    logic signed [COST_BITS-1:0] dist_a_reg;
    logic signed [COST_BITS-1:0] dist_b_reg;
    logic signed [COST_BITS-1:0] cand_reg;
    logic signed [COST_BITS-1:0] cand_next;
    logic signed [COST_BITS:0]   sum;
    logic [MAX_VERTICES-1:0]     mark_reg;
    logic [MAX_VERTICES-1:0]     mark_next;
    logic                        wr_en;
    logic [VW-1:0]               wr_addr;
    logic signed [COST_BITS-1:0] wr_data;

    // saturating dist[u] + weight
    always_comb
    begin
        sum = (COST_BITS+1)'(dist_a_reg) + (COST_BITS+1)'(weight);
        if (sum[COST_BITS] != sum[COST_BITS-1])
        begin
            cand_next = sum[COST_BITS] ? COST_MIN : COST_MAX;
        end
        else
        begin
            cand_next = sum[COST_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cand_ld)
        begin
            cand_reg <= cand_next;
        end
    end

    // relax test against the current distance of v
    assign sts.better = !mark_reg[addr_v] || (cand_reg < dist_b_reg);
    assign sts.mark_u = mark_reg[addr_u];

    // single write port: seed or commit
    assign wr_en   = ctl.seed || ctl.commit;
    assign wr_addr = ctl.seed ? addr_u : addr_v;
    assign wr_data = ctl.seed ? '0 : cand_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wr_addr] <= wr_data;
        end
        if (ctl.dist_rd)
        begin
            dist_a_reg <= dist_mem[addr_u];
            dist_b_reg <= dist_mem[addr_v];
        end
    end

    // reached marks
    always_comb
    begin
        mark_next = mark_reg;
        if (ctl.clear_marks)
        begin
            mark_next = '0;
        end
        if (wr_en)
        begin
            mark_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    assign dist_a = dist_a_reg;

endmodule

/* dv/testbench.sv */
// Testbench for bellman_ford_shortest_paths: streams edge lists, solves each graph in a
// local shortest-path predictor and checks every result the block strobes out.
// Depends on bfsp_pkg and the RTL in rtl/; needs nothing else.
module testbench;
    import bfsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;
    localparam int VTX_LIMIT   = 32;
    localparam int W_BITS      = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [VTX_BITS-1:0]         vertex;
        logic signed [COST_BITS-1:0] path_cost;
        logic                        reachable;
        logic                        negative_cycle;
        logic                        last;
    } sp_result_t;

    // DUT signals; every input starts at a known value
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0]    paddr = '0;
    logic [CFG_DATA_BITS-1:0]    pwdata = '0;
    logic [CFG_DATA_BITS-1:0]    prdata;
    logic                        pready;
    logic                        start = 1'b0;
    logic                        busy;
    logic [VTX_BITS-1:0]         edge_from = '0;
    logic [VTX_BITS-1:0]         edge_to = '0;
    logic signed [W_BITS-1:0]    edge_weight = '0;
    logic                        last_edge = 1'b0;
    logic                        done;
    logic [VTX_BITS-1:0]         vertex;
    logic signed [COST_BITS-1:0] path_cost;
    logic                        reachable;
    logic                        negative_cycle;
    logic                        last;

    // predictor state: stored edges, registers, per-vertex distances
    logic [VTX_BITS-1:0]         tbl_from [TABLE_DEPTH];
    logic [VTX_BITS-1:0]         tbl_to [TABLE_DEPTH];
    logic signed [W_BITS-1:0]    tbl_weight [TABLE_DEPTH];
    int                          tbl_count = 0;
    logic [VC_BITS-1:0]          cfg_vertex_count = VC_RESET;
    logic [VTX_BITS-1:0]         cfg_source = SRC_RESET;
    logic signed [COST_BITS-1:0] dist_est [VTX_LIMIT];
    logic                        reached [VTX_LIMIT];

    sp_result_t expected_paths[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  graphs_solved = 0;
    int  edges_sent = 0;
    int  results_checked = 0;
    bit  steady = 1'b0;

    bellman_ford_shortest_paths dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .edge_from      (edge_from),
        .edge_to        (edge_to),
        .edge_weight    (edge_weight),
        .last_edge      (last_edge),
        .done           (done),
        .vertex         (vertex),
        .path_cost      (path_cost),
        .reachable      (reachable),
        .negative_cycle (negative_cycle),
        .last           (last)
    );

    always #2 clk = ~clk;

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // vertex count as the block uses it: held to 2..VTX_LIMIT
    function automatic int clamp_count(input int vc);
        if (vc < 2)
            return 2;
        if (vc > VTX_LIMIT)
            return VTX_LIMIT;
        return vc;
    endfunction

    function automatic logic signed [COST_BITS-1:0] sat_sum(
        input logic signed [COST_BITS-1:0] base,
        input logic signed [W_BITS-1:0]    step
    );
        longint total;
        total = longint'(base) + longint'(step);
        if (total > longint'(COST_MAX))
            return COST_MAX;
        if (total < longint'(COST_MIN))
            return COST_MIN;
        return COST_BITS'(total);
    endfunction

    // one sweep over the stored edges; reports whether any edge still improves
    function automatic bit relax_sweep(input int n, input bit apply);
        bit                          changed;
        int                          u;
        int                          v;
        logic signed [COST_BITS-1:0] cand;
        changed = 1'b0;
        for (int e = 0; e < tbl_count; e++)
        begin
            u = int'(tbl_from[e]);
            v = int'(tbl_to[e]);
            if (u == 0 || u >= n || v == 0 || v >= n)
                continue;
            if (!reached[u])
                continue;
            cand = sat_sum(dist_est[u], tbl_weight[e]);
            if (!reached[v] || cand < dist_est[v])
            begin
                changed = 1'b1;
                if (!apply)
                    return 1'b1;
                dist_est[v] = cand;
                reached[v] = 1'b1;
            end
        end
        return changed;
    endfunction

    // full run on the stored graph; queues the results it should produce
    function automatic void solve_shortest_paths();
        int         n;
        bit         looped;
        sp_result_t r;
        n = clamp_count(int'(cfg_vertex_count));
        for (int v = 0; v < VTX_LIMIT; v++)
        begin
            dist_est[v] = '0;
            reached[v] = 1'b0;
        end
        if (cfg_source >= 1 && int'(cfg_source) < n)
            reached[cfg_source] = 1'b1;
        for (int p = 0; p + 2 < n; p++)
            void'(relax_sweep(n, 1'b1));
        looped = relax_sweep(n, 1'b0);
        tbl_count = 0;
        graphs_solved++;
        if (looped)
        begin
            r.vertex = '0;
            r.path_cost = '0;
            r.reachable = 1'b0;
            r.negative_cycle = 1'b1;
            r.last = 1'b1;
            expected_paths.insert(expected_paths.size(), r);
        end
        else
        begin
            for (int v = 1; v < n; v++)
            begin
                r.vertex = VTX_BITS'(v);
                r.path_cost = reached[v] ? dist_est[v] : '0;
                r.reachable = reached[v];
                r.negative_cycle = 1'b0;
                r.last = (v + 1 == n);
                expected_paths.insert(expected_paths.size(), r);
            end
        end
    endfunction

    // random sender gap after a request, skipped during steady stretches
    task automatic pause_sender();
        if (!steady && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
    endtask

    // present one edge request and hold it until the block takes it
    task automatic send_edge(
        input logic [VTX_BITS-1:0]      from_v,
        input logic [VTX_BITS-1:0]      to_v,
        input logic signed [W_BITS-1:0] weight,
        input logic                     fin
    );
        start <= 1'b1;
        edge_from <= from_v;
        edge_to <= to_v;
        edge_weight <= weight;
        last_edge <= fin;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        edges_sent++;
        // table drops edges once full; a dropped last edge still starts the run
        if (tbl_count < TABLE_DEPTH)
        begin
            tbl_from[tbl_count] = from_v;
            tbl_to[tbl_count] = to_v;
            tbl_weight[tbl_count] = weight;
            tbl_count++;
        end
        if (fin)
            solve_shortest_paths();
        pause_sender();
    endtask

    // stop sending and wait until the block has delivered everything and gone idle
    task automatic drain_results();
        start <= 1'b0;
        while (expected_paths.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // APB write, then read back; junk above the field must not stick
    task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] value);
        logic [CFG_DATA_BITS-1:0] data;
        logic [CFG_DATA_BITS-1:0] readback_want;
        data = $urandom();
        if (idx == REG_VERTEX_COUNT)
        begin
            data[VC_BITS-1:0] = value[VC_BITS-1:0];
            readback_want = CFG_DATA_BITS'(value[VC_BITS-1:0]);
        end
        else
        begin
            data[VTX_BITS-1:0] = value[VTX_BITS-1:0];
            readback_want = CFG_DATA_BITS'(value[VTX_BITS-1:0]);
        end
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_VERTEX_COUNT)
            cfg_vertex_count = value[VC_BITS-1:0];
        else
            cfg_source = value[VTX_BITS-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== readback_want)
            flag_error($sformatf("register %0d read 0x%08h, expected 0x%08h",
                                 idx, prdata, readback_want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int vc, input int src);
        drain_results();
        write_reg(REG_VERTEX_COUNT, CFG_DATA_BITS'(vc));
        write_reg(REG_SOURCE_VERTEX, CFG_DATA_BITS'(src));
    endtask

    function automatic logic signed [W_BITS-1:0] pick_weight();
        int sel;
        int w;
        sel = $urandom_range(99);
        if (sel < 55)
            w = $urandom_range(200);
        else if (sel < 75)
            w = -int'($urandom_range(60, 1));
        else if (sel < 90)
            w = $urandom();
        else
            w = $urandom_range(1) ? 32767 : -32768;
        return W_BITS'(w);
    endfunction

    // reset registers: full-size graph, weight extremes, endpoints at 0 and 31
    task automatic test_reset_config_graph();
        send_edge(5'd1, 5'd2, 16'sd32767, 1'b0);
        send_edge(5'd2, 5'd31, -16'sd32768, 1'b0);
        send_edge(5'd31, 5'd30, 16'sd0, 1'b0);
        send_edge(5'd0, 5'd5, 16'sd7, 1'b0);
        send_edge(5'd5, 5'd0, 16'sd3, 1'b0);
        send_edge(5'd3, 5'd4, -16'sd1, 1'b1);
    endtask

    // reachable loop below zero, then one the source cannot reach
    task automatic test_negative_cycles();
        configure(6, 2);
        send_edge(5'd2, 5'd3, 16'sd4, 1'b0);
        send_edge(5'd3, 5'd4, -16'sd3, 1'b0);
        send_edge(5'd4, 5'd3, 16'sd1, 1'b1);
        send_edge(5'd2, 5'd1, 16'sd5, 1'b0);
        send_edge(5'd3, 5'd4, -16'sd9, 1'b0);
        send_edge(5'd4, 5'd3, -16'sd9, 1'b1);
    endtask

    // smallest graph, clamped counts below and above range, largest source
    task automatic test_vertex_count_limits();
        configure(2, 1);
        send_edge(5'd1, 5'd1, -16'sd1, 1'b1);
        send_edge(5'd1, 5'd1, 16'sd5, 1'b1);
        configure(0, 1);
        send_edge(5'd1, 5'd2, 16'sd3, 1'b1);
        configure(1, 1);
        send_edge(5'd1, 5'd2, 16'sd3, 1'b1);
        configure(63, 31);
        send_edge(5'd31, 5'd1, -16'sd7, 1'b0);
        send_edge(5'd1, 5'd31, 16'sd10, 1'b1);
        configure(33, 1);
        send_edge(5'd1, 5'd31, -16'sd32768, 1'b1);
    endtask

    // source zero and source past the vertex range reach nothing, then a source at the top of the range
    task automatic test_source_outside();
        configure(8, 0);
        send_edge(5'd1, 5'd2, 16'sd1, 1'b1);
        configure(8, 9);
        send_edge(5'd1, 5'd2, 16'sd1, 1'b1);
        configure(8, 7);
        send_edge(5'd7, 5'd1, 16'sd2, 1'b0);
        send_edge(5'd1, 5'd7, -16'sd2, 1'b1);
    endtask

    // fill the edge table; the extra last edge is dropped but still starts the run
    task automatic test_table_overflow();
        logic [VTX_BITS-1:0] b;
        configure(4, 1);
        for (int i = 0; i < TABLE_DEPTH - 1; i++)
        begin
            b = VTX_BITS'($urandom_range(31));
            if (b == 5'd2)
                b = 5'd3;
            send_edge(VTX_BITS'($urandom_range(31)), b, W_BITS'($urandom_range(1000)), 1'b0);
        end
        send_edge(5'd1, 5'd3, 16'sd50, 1'b0);
        send_edge(5'd1, 5'd2, -16'sd500, 1'b1);
        // table must be empty again
        send_edge(5'd1, 5'd2, 16'sd7, 1'b1);
    endtask

    // random graphs: mostly chains walking out from the source, some noise edges
    task automatic test_random_graphs();
        int                  sent;
        int                  sel;
        int                  vc;
        int                  n;
        int                  edges;
        logic [VTX_BITS-1:0] hop;
        logic [VTX_BITS-1:0] a;
        logic [VTX_BITS-1:0] b;
        sent = 0;
        steady = 1'b1;
        while (sent < 110)
        begin
            if (sent > 40)
                steady = 1'b0;
            if (sent == 0 || $urandom_range(99) < 55)
            begin
                sel = $urandom_range(99);
                if (sel < 10)
                    vc = 2;
                else if (sel < 18)
                    vc = VTX_LIMIT;
                else if (sel < 26)
                    vc = $urandom_range(63);
                else
                    vc = $urandom_range(12, 3);
                if ($urandom_range(99) < 15)
                    configure(vc, $urandom_range(31));
                else
                    configure(vc, $urandom_range(clamp_count(vc) - 1, 1));
            end
            n = clamp_count(int'(cfg_vertex_count));
            edges = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(24, 9);
            hop = cfg_source;
            for (int i = 0; i < edges; i++)
            begin
                if ($urandom_range(99) < 20)
                begin
                    a = VTX_BITS'($urandom_range(31));
                    b = VTX_BITS'($urandom_range(31));
                end
                else
                begin
                    a = $urandom_range(1) ? hop : VTX_BITS'($urandom_range(n - 1, 1));
                    b = VTX_BITS'($urandom_range(n - 1, 1));
                    hop = b;
                end
                send_edge(a, b, pick_weight(), i == edges - 1);
                sent++;
            end
        end
    endtask

    // result checker: the block strobes each result for one cycle and cannot stall
    always @(posedge clk)
    begin : check_results
        sp_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_paths.size() == 0)
                flag_error($sformatf("result for vertex %0d with nothing pending", vertex));
            else
            begin
                want = expected_paths.pop_front();
                results_checked++;
                if (vertex !== want.vertex || path_cost !== want.path_cost ||
                    reachable !== want.reachable ||
                    negative_cycle !== want.negative_cycle || last !== want.last)
                    flag_error($sformatf(
                        {"got v%0d cost %0d reach %b cyc %b last %b, ",
                         "want v%0d cost %0d reach %b cyc %b last %b"},
                        vertex, path_cost, reachable, negative_cycle, last,
                        want.vertex, want.path_cost, want.reachable,
                        want.negative_cycle, want.last));
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config_graph();
        test_negative_cycles();
        test_vertex_count_limits();
        test_source_outside();
        test_table_overflow();
        test_random_graphs();
        drain_results();
        repeat (40) @(posedge clk);
        if (expected_paths.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_paths.size()));
        $display("Solved %0d graphs from %0d edge requests, %0d results compared, %0d errors.",
                 graphs_solved, edges_sent, results_checked, error_count);
        $display("Covered clamped sizes 2..32, stray sources and endpoints, negative loops, full table.");
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/bfsp_pkg.sv
rtl/bfsp_edge_table.sv
rtl/bfsp_relax.sv
rtl/bellman_ford_shortest_paths.sv
dv/testbench.sv
